### src/cle_pkg.sv
// Shared types and codes for the circular list engine.
package cle_pkg;

    localparam int POS_W = 16;
    localparam int VAL_W = 32;

    // Input function codes
    localparam logic [2:0] FUNC_READ      = 3'd0;
    localparam logic [2:0] FUNC_INS_FRONT = 3'd1;
    localparam logic [2:0] FUNC_INS_BACK  = 3'd2;
    localparam logic [2:0] FUNC_INS_AT    = 3'd3;
    localparam logic [2:0] FUNC_REM_AT    = 3'd4;
    localparam logic [2:0] FUNC_REM_VAL   = 3'd5;

    // Internal command kinds
    localparam logic [2:0] OP_NOP       = 3'd0;
    localparam logic [2:0] OP_READ      = 3'd1;
    localparam logic [2:0] OP_INS_FRONT = 3'd2;
    localparam logic [2:0] OP_INS_BACK  = 3'd3;
    localparam logic [2:0] OP_INS_AT    = 3'd4;
    localparam logic [2:0] OP_REM_AT    = 3'd5;
    localparam logic [2:0] OP_REM_VAL   = 3'd6;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]              kind;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

endpackage

### src/cle_front.sv
// Front end: accepts input transfers and classifies them into commands.
module cle_front
    import cle_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              in_func,
    input  logic [POS_W-1:0]        in_pos,
    input  logic signed [VAL_W-1:0] in_value,
    output logic                    cmd_valid,
    input  logic                    cmd_ready,
    output cmd_t                    cmd
);

    logic fv_reg;
    cmd_t fcmd_reg;
    cmd_t dec;

    // Decode function code; insert at position is reduced to max(p,1)-1
    always_comb begin
        dec.pos   = in_pos;
        dec.value = in_value;
        unique case (in_func)
            FUNC_READ:      dec.kind = OP_READ;
            FUNC_INS_FRONT: dec.kind = OP_INS_FRONT;
            FUNC_INS_BACK:  dec.kind = OP_INS_BACK;
            FUNC_INS_AT: begin
                dec.kind = OP_INS_AT;
                dec.pos  = (in_pos == '0) ? '0 : in_pos - POS_W'(1);
            end
            FUNC_REM_AT:    dec.kind = OP_REM_AT;
            FUNC_REM_VAL:   dec.kind = OP_REM_VAL;
            default:        dec.kind = OP_NOP;
        endcase
    end

    assign in_ready  = !fv_reg || cmd_ready;
    assign cmd_valid = fv_reg;
    assign cmd       = fcmd_reg;

    // Hold stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (in_ready) begin
            fv_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            fcmd_reg <= dec;
        end
    end

endmodule

### src/cle_queue.sv
// Two-entry command queue between front and back end.
module cle_queue
    import cle_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_cmd
);

    cmd_t       slot_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_cmd   = slot_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            if (push && !pop)      fill_reg <= fill_reg + 2'd1;
            else if (pop && !push) fill_reg <= fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= wr_cmd;
        end
    end

endmodule

### src/cle_divu.sv
// Restoring remainder unit: one dividend bit per cycle.
module cle_divu
    import cle_pkg::*;
#(
    parameter int CNT_W = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [CNT_W-1:0] rem
);

    localparam int BIT_W = $clog2(POS_W);

    logic             busy_reg;
    logic             done_reg;
    logic [BIT_W-1:0] bit_reg;
    logic [POS_W-1:0] num_reg;
    logic [CNT_W-1:0] den_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic [CNT_W-1:0] rem_next;

    // One trial subtraction
    always_comb begin
        trial    = {rem_reg, num_reg[POS_W-1]};
        diff     = trial - {1'b0, den_reg};
        rem_next = (trial >= {1'b0, den_reg}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            bit_reg <= BIT_W'(POS_W - 1);
        end else if (busy_reg) begin
            num_reg <= {num_reg[POS_W-2:0], 1'b0};
            rem_reg <= rem_next;
            bit_reg <= bit_reg - BIT_W'(1);
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### src/cle_back.sv
// Back end: node memories, list walker and result register.
module cle_back
    import cle_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int IDX_W    = 8,
    parameter int CNT_W    = 9
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  cmd_t                    cmd,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              out_status,
    output logic signed [VAL_W-1:0] out_read_value,
    output logic [CNT_W-1:0]        out_removed,
    output logic [CNT_W-1:0]        out_length
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIV    = 4'd1;
    localparam logic [3:0] ST_WALK   = 4'd2;
    localparam logic [3:0] ST_RDV    = 4'd3;
    localparam logic [3:0] ST_FETCH  = 4'd4;
    localparam logic [3:0] ST_FETCHW = 4'd5;
    localparam logic [3:0] ST_SCANRD = 4'd6;
    localparam logic [3:0] ST_SCANEV = 4'd7;
    localparam logic [3:0] ST_UNL1   = 4'd8;
    localparam logic [3:0] ST_UNL2   = 4'd9;
    localparam logic [3:0] ST_INSA   = 4'd10;
    localparam logic [3:0] ST_INSB   = 4'd11;
    localparam logic [3:0] ST_INSC   = 4'd12;
    localparam logic [3:0] ST_INSD   = 4'd13;
    localparam logic [3:0] ST_DONE   = 4'd14;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Node memories
    logic signed [VAL_W-1:0] val_mem [CAPACITY];
    logic [IDX_W-1:0]        link_mem [CAPACITY];

    logic [3:0]              st_reg, st_next;
    cmd_t                    cmd_reg;
    logic [IDX_W-1:0]        tail_reg, free_head_reg;
    logic [CNT_W-1:0]        fresh_reg, count_reg;
    logic [CNT_W-1:0]        steps_reg, removed_reg;
    logic [IDX_W-1:0]        cur_reg, node_reg, next_reg;
    logic                    scan_reg;
    logic [1:0]              status_reg;
    logic signed [VAL_W-1:0] rdval_reg;

    logic                    ov_reg;
    logic [1:0]              o_status_reg;
    logic signed [VAL_W-1:0] o_rdval_reg;
    logic [CNT_W-1:0]        o_removed_reg, o_length_reg;

    logic [IDX_W-1:0]        link_raddr, link_waddr, link_wdata, link_rdata_reg;
    logic                    link_we;
    logic [IDX_W-1:0]        val_raddr;
    logic signed [VAL_W-1:0] val_rdata_reg;
    logic                    val_we;

    logic                    div_start, div_done;
    logic [CNT_W-1:0]        div_rem;
    logic                    div_go_reg;
    logic                    recycled;
    logic                    out_load;
    logic                    match;

    cle_divu #(.CNT_W(CNT_W)) u_divu (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cmd_reg.pos),
        .divisor  (count_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign cmd_ready = (st_reg == ST_IDLE);
    assign recycled  = (fresh_reg != count_reg);
    assign out_load  = (st_reg == ST_DONE) && (!ov_reg || out_ready);
    assign match     = !scan_reg || (val_rdata_reg == cmd_reg.value);

    // Memory ports
    always_ff @(posedge aclk) begin
        if (link_we) link_mem[link_waddr] <= link_wdata;
        link_rdata_reg <= link_mem[link_raddr];
    end

    always_ff @(posedge aclk) begin
        if (val_we) val_mem[node_reg] <= cmd_reg.value;
        val_rdata_reg <= val_mem[val_raddr];
    end

    // Sequencer next state and memory controls
    always_comb begin
        st_next    = st_reg;
        link_raddr = cur_reg;
        link_we    = 1'b0;
        link_waddr = cur_reg;
        link_wdata = next_reg;
        val_raddr  = node_reg;
        val_we     = 1'b0;
        div_start  = div_go_reg;
        unique case (st_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    priority if (cmd.kind == OP_NOP) begin
                        st_next = ST_DONE;
                    end else if (cmd.kind == OP_READ || cmd.kind == OP_REM_AT
                                 || cmd.kind == OP_REM_VAL) begin
                        if (count_reg == '0)            st_next = ST_DONE;
                        else if (cmd.kind == OP_REM_VAL) st_next = ST_FETCH;
                        else                             st_next = ST_DIV;
                    end else begin
                        if (count_reg == CAP_CNT) st_next = ST_DONE;
                        else if (cmd.kind == OP_INS_AT && count_reg != '0) st_next = ST_DIV;
                        else st_next = ST_INSA;
                    end
                end
            end
            ST_DIV: begin
                link_raddr = tail_reg;
                if (div_done) begin
                    if (cmd_reg.kind == OP_REM_AT && div_rem == '0) st_next = ST_FETCH;
                    else st_next = ST_WALK;
                end
            end
            ST_WALK: begin
                link_raddr = link_rdata_reg;
                val_raddr  = link_rdata_reg;
                if (steps_reg == CNT_W'(1)) begin
                    priority if (cmd_reg.kind == OP_READ) st_next = ST_RDV;
                    else if (cmd_reg.kind == OP_INS_AT)  st_next = ST_INSA;
                    else                                 st_next = ST_FETCH;
                end
            end
            ST_RDV:    st_next = ST_DONE;
            ST_FETCH:  st_next = ST_FETCHW;
            ST_FETCHW: st_next = ST_SCANRD;
            ST_SCANRD: begin
                link_raddr = node_reg;
                st_next    = ST_SCANEV;
            end
            ST_SCANEV: begin
                if (match)                        st_next = ST_UNL1;
                else if (steps_reg == CNT_W'(1))  st_next = ST_DONE;
                else                              st_next = ST_SCANRD;
            end
            ST_UNL1: begin
                link_we = 1'b1;
                st_next = ST_UNL2;
            end
            ST_UNL2: begin
                link_we    = 1'b1;
                link_waddr = node_reg;
                link_wdata = free_head_reg;
                if (!scan_reg || steps_reg == CNT_W'(1)) st_next = ST_DONE;
                else                                     st_next = ST_SCANRD;
            end
            ST_INSA: st_next = ST_INSB;
            ST_INSB: begin
                link_raddr = free_head_reg;
                st_next    = ST_INSC;
            end
            ST_INSC: begin
                val_we     = 1'b1;
                link_we    = 1'b1;
                link_waddr = node_reg;
                link_wdata = (count_reg == '0) ? node_reg : next_reg;
                st_next    = ST_INSD;
            end
            ST_INSD: begin
                link_we    = (count_reg != '0);
                link_wdata = node_reg;
                st_next    = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_IDLE;
            tail_reg      <= '0;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            count_reg     <= '0;
            ov_reg        <= 1'b0;
        end else begin
            st_reg <= st_next;
            unique case (st_reg)
                ST_UNL1: begin
                    if (node_reg == tail_reg)
                        tail_reg <= (cur_reg != node_reg) ? cur_reg : '0;
                end
                ST_UNL2: begin
                    free_head_reg <= node_reg;
                    count_reg     <= count_reg - CNT_W'(1);
                end
                ST_INSC: begin
                    if (recycled) free_head_reg <= link_rdata_reg;
                    else          fresh_reg     <= fresh_reg + CNT_W'(1);
                end
                ST_INSD: begin
                    if (count_reg == '0 || cmd_reg.kind == OP_INS_BACK
                        || (cmd_reg.kind == OP_INS_AT && cur_reg == tail_reg))
                        tail_reg <= node_reg;
                    count_reg <= count_reg + CNT_W'(1);
                end
                default: ;
            endcase
            if (out_load)       ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    // Registered divider start pulse, raised as the sequencer enters the division state,
    // once the command and the entry count are registered
    always_ff @(posedge aclk) begin
        if (!aresetn) div_go_reg <= 1'b0;
        else          div_go_reg <= (st_reg == ST_IDLE) && (st_next == ST_DIV);
    end

    // Working registers
    always_ff @(posedge aclk) begin
        unique case (st_reg)
            ST_IDLE: begin
                cmd_reg     <= cmd;
                cur_reg     <= tail_reg;
                steps_reg   <= count_reg;
                scan_reg    <= (cmd.kind == OP_REM_VAL);
                removed_reg <= '0;
                rdval_reg   <= '0;
                status_reg  <= STAT_OK;
                if ((cmd.kind == OP_READ || cmd.kind == OP_REM_AT
                     || cmd.kind == OP_REM_VAL) && count_reg == '0)
                    status_reg <= STAT_EMPTY;
                if ((cmd.kind == OP_INS_FRONT || cmd.kind == OP_INS_BACK
                     || cmd.kind == OP_INS_AT) && count_reg == CAP_CNT)
                    status_reg <= STAT_FULL;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (cmd_reg.kind == OP_REM_AT) steps_reg <= div_rem;
                    else                           steps_reg <= div_rem + CNT_W'(1);
                end
            end
            ST_WALK: begin
                steps_reg <= steps_reg - CNT_W'(1);
                cur_reg   <= link_rdata_reg;
            end
            ST_RDV:    rdval_reg <= val_rdata_reg;
            ST_FETCHW: node_reg  <= link_rdata_reg;
            ST_SCANEV: begin
                next_reg <= link_rdata_reg;
                if (!match) begin
                    cur_reg   <= node_reg;
                    node_reg  <= link_rdata_reg;
                    steps_reg <= steps_reg - CNT_W'(1);
                end
            end
            ST_UNL2: begin
                removed_reg <= removed_reg + CNT_W'(1);
                node_reg    <= next_reg;
                steps_reg   <= steps_reg - CNT_W'(1);
            end
            ST_INSB: begin
                next_reg <= link_rdata_reg;
                node_reg <= recycled ? free_head_reg : fresh_reg[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            o_status_reg  <= status_reg;
            o_rdval_reg   <= rdval_reg;
            o_removed_reg <= removed_reg;
            o_length_reg  <= count_reg;
        end
    end

    assign out_valid      = ov_reg;
    assign out_status     = o_status_reg;
    assign out_read_value = o_rdval_reg;
    assign out_removed    = o_removed_reg;
    assign out_length     = o_length_reg;

    // Entry count never passes capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT) else $error("entry count above capacity");

    // Every live node came from the fresh range
    a_count_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= fresh_reg) else $error("entry count above allocated nodes");

    // A loaded result returns the sequencer to idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> st_reg == ST_IDLE) else $error("sequencer did not return to idle");

    // The divider is started only inside the division state
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> st_reg == ST_DIV) else $error("stray divider start");

endmodule

### src/circular_list_engine_unit.sv
// Top level of the circular list engine.
//
// Circular list engine: keeps an ordered circular list of up to CAPACITY signed
// 32-bit values in node value and link memories, one command per input transfer
// and one result transfer per command. Read, insert at position (on a non-empty
// list) and remove at position first reduce the position modulo the current
// length in a bit-serial remainder unit, then walk the link memory one node per
// cycle where needed, then finish. Remove by value visits every entry. The
// memories need no clearing pass after reset: freed nodes are reused first, and
// unused nodes are handed out from a fill counter only when none is free.
// Commands are queued between the input side and the sequencer, and a result
// register lets the next command start while a result waits.
module circular_list_engine_unit
    import cle_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [2:0] func, [18:3] position, [50:19] item_value, zero fill above
    input  logic [55:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] status, [33:2] read_value, removed_count, length, zero fill above
    output logic [((2 + VAL_W + 2 * $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int OUT_W = ((2 + VAL_W + 2 * CNT_W + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - (2 + VAL_W + 2 * CNT_W);

    logic                    f_valid, f_ready, q_valid, q_ready;
    cmd_t                    f_cmd, q_cmd;
    logic [1:0]              r_status;
    logic signed [VAL_W-1:0] r_rdval;
    logic [CNT_W-1:0]        r_removed, r_length;
    logic [PAD_W:0]          pad;

    cle_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tdata[2:0]),
        .in_pos    (s_tdata[18:3]),
        .in_value  (s_tdata[50:19]),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    cle_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_cmd   (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_cmd   (q_cmd)
    );

    cle_back #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (q_valid),
        .cmd_ready      (q_ready),
        .cmd            (q_cmd),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (r_status),
        .out_read_value (r_rdval),
        .out_removed    (r_removed),
        .out_length     (r_length)
    );

    // Pack result fields, lowest first
    assign pad     = '0;
    assign m_tdata = OUT_W'({pad, r_length, r_removed, r_rdval, r_status});

endmodule
